>>> rtl/step_dir_pulse_generator_macros.svh
// Assertion macros for the step/direction pulse generator.
// Expects signals clk and rst in the scope of use.
`ifndef STEP_DIR_PULSE_GENERATOR_MACROS_SVH
`define STEP_DIR_PULSE_GENERATOR_MACROS_SVH

// antecedent implies consequent in the same cycle
`define SDPG_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define SDPG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/sdpg_pkg.sv
// Types and constants shared by the step/direction pulse generator.
// No dependencies.
`default_nettype none

package sdpg_pkg;

  typedef enum logic [1:0] {
    MODE_TICK   = 2'd0,
    MODE_SPEED  = 2'd1,
    MODE_ENABLE = 2'd2,
    MODE_STOP   = 2'd3
  } mode_t;

  localparam logic [1:0] CFG_PERIOD_MAX = 2'd0;
  localparam logic [1:0] CFG_PERIOD_MIN = 2'd1;
  localparam logic [1:0] CFG_ENABLE_LVL = 2'd2;
  localparam logic [1:0] CFG_UNIT_ID    = 2'd3;

  localparam logic [15:0] PERIOD_MAX_RST = 16'd1000;
  localparam logic [15:0] PERIOD_MIN_RST = 16'd100;
  localparam logic [7:0]  UNIT_ID_RST    = 8'd1;
  localparam logic [15:0] RESET_PERIOD   = 16'd250;

  localparam logic [1:0]  DIRN_NONE      = 2'd0;
  localparam logic [1:0]  DIRN_FWD       = 2'd1;
  localparam logic [7:0]  BROADCAST_ID   = 8'hFF;
  localparam logic [15:0] MIN_PHASE      = 16'd2;

  // full speed, 100 percent in Q8
  localparam logic [14:0] FULL_SPEED_Q8  = 15'd25600;
  // floor(2^30 / 100); estimate is low by at most one
  localparam logic [23:0] RECIP_100      = 24'd10737418;
  localparam logic [25:0] DIV_100        = 26'd100;

  typedef struct packed {
    mode_t       mode;
    logic [7:0]  target_id;
    logic [1:0]  direction;
    logic        enable_request;
  } cmd_t;

  typedef struct packed {
    cmd_t        cmd;
    logic        speed_zero;
    logic [15:0] period;
  } mapped_t;

endpackage

`default_nettype wire

>>> rtl/sdpg_period_map.sv
// Four-stage pipeline mapping a Q8 percent speed onto a step period.
// Depends on sdpg_pkg.
`default_nettype none

module sdpg_period_map
  import sdpg_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire cmd_t               in_cmd,
  input  wire logic signed [15:0] in_speed,
  input  wire logic [15:0]        period_max,
  input  wire logic [15:0]        period_min,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output mapped_t                 out_item
);

  logic [3:0] v;
  logic [3:0] rdy;

  cmd_t               cmd0;
  logic signed [15:0] spd0;
  cmd_t               cmd1;
  logic               zero1;
  logic signed [32:0] prod1;
  logic [30:0]        base1;
  cmd_t               cmd2;
  logic               zero2;
  logic [23:0]        x2;
  logic [47:0]        est2;

  logic [14:0]        s_cl;
  logic signed [16:0] diff;
  logic signed [32:0] prod_a;
  logic [30:0]        base_a;
  logic signed [33:0] num_b;
  logic [31:0]        numc_b;
  logic [23:0]        x_b;
  logic [47:0]        est_b;
  logic [17:0]        qe_c;
  logic [25:0]        qx_c;
  logic [25:0]        rem_c;
  logic [17:0]        q_c;
  logic [15:0]        per_c;

  always_comb begin
    rdy[3] = !v[3] || out_ready;
    for (int i = 2; i >= 0; i--) begin
      rdy[i] = !v[i] || rdy[i+1];
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = v[3];

  // clamp, then difference times speed
  always_comb begin
    if (spd0[15]) begin
      s_cl = '0;
    end else if (spd0[14:0] > FULL_SPEED_Q8) begin
      s_cl = FULL_SPEED_Q8;
    end else begin
      s_cl = spd0[14:0];
    end
    diff   = $signed({1'b0, period_max}) - $signed({1'b0, period_min});
    prod_a = diff * $signed({1'b0, s_cl});
    base_a = period_max * FULL_SPEED_Q8;
  end

  // numerator, floor by 256, reciprocal of 100
  always_comb begin
    num_b  = $signed({3'b000, base1}) - $signed({prod1[32], prod1});
    numc_b = num_b[33] ? 32'd0 : num_b[31:0];
    x_b    = numc_b[31:8];
    est_b  = x_b * RECIP_100;
  end

  // correct the quotient, then clamp
  always_comb begin
    qe_c  = est2[47:30];
    qx_c  = {8'd0, qe_c} * DIV_100;
    rem_c = {2'b00, x2} - qx_c;
    q_c   = (rem_c >= DIV_100) ? qe_c + 18'd1 : qe_c;
    if (q_c < {2'b00, period_min}) begin
      q_c = {2'b00, period_min};
    end
    if (q_c > {2'b00, period_max}) begin
      q_c = {2'b00, period_max};
    end
    per_c = q_c[15:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (rdy[0]) v[0] <= in_valid;
      if (rdy[1]) v[1] <= v[0];
      if (rdy[2]) v[2] <= v[1];
      if (rdy[3]) v[3] <= v[2];
    end
    if (rdy[0]) begin
      cmd0 <= in_cmd;
      spd0 <= in_speed;
    end
    if (rdy[1]) begin
      cmd1  <= cmd0;
      zero1 <= (s_cl == '0);
      prod1 <= prod_a;
      base1 <= base_a;
    end
    if (rdy[2]) begin
      cmd2  <= cmd1;
      zero2 <= zero1;
      x2    <= x_b;
      est2  <= est_b;
    end
    if (rdy[3]) begin
      out_item.cmd        <= cmd2;
      out_item.speed_zero <= zero2;
      out_item.period     <= per_c;
    end
  end

endmodule

`default_nettype wire

>>> rtl/step_dir_pulse_generator.sv
// Top level of the step/direction pulse generator: config registers,
// pulse state and result register. Depends on sdpg_pkg, sdpg_period_map
// and step_dir_pulse_generator_macros.svh.
//
//  channel   dir  beat content
//  s_axis    in   tuser[1:0] mode; tdata target_id, speed_pct_q8, direction,
//                 enable_request
//  m_axis    out  tdata step_level, dir_level, enable_pin_level, running,
//                 period_us
//  cfg       in   cfg_we, cfg_index, cfg_data; one register per write
//
// One beat in and one result out per clock while m_axis is not stalled;
// each result passes through the input register, clamp and multiply,
// reciprocal multiply, correction and clamp in the period mapper, then the
// pulse state and result register.
// Synchronous reset restores the register defaults, period 250, forward,
// driver enabled, pulses stopped.
// Each stage moves when the next has room, so a stalled m_axis fills the
// pipeline before s_axis_tready drops.
`default_nettype none

`include "step_dir_pulse_generator_macros.svh"

module step_dir_pulse_generator
  import sdpg_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // [7:0] target_id, [23:8] speed_pct_q8, [25:24] direction,
  // [26] enable_request, [31:27] zero
  input  wire logic [31:0] s_axis_tdata,
  // [1:0] mode
  input  wire logic [1:0]  s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [0] step_level, [1] dir_level, [2] enable_pin_level, [3] running,
  // [19:4] period_us, [23:20] zero
  output logic [23:0]      m_axis_tdata,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  logic [15:0] period_max_us;
  logic [15:0] period_min_us;
  logic        enable_active_level;
  logic [7:0]  unit_id;

  logic        run_flag;
  logic [15:0] period_reg;
  logic        dir_reg;
  logic        enabled_reg;
  logic        high_phase;
  logic [15:0] phase_left;
  logic [15:0] low_len_latched;

  logic        run_flag_next;
  logic [15:0] period_reg_next;
  logic        dir_reg_next;
  logic        enabled_reg_next;
  logic        high_phase_next;
  logic [15:0] phase_left_next;
  logic [15:0] low_len_latched_next;
  logic        step_next;
  logic [15:0] hi_len;
  logic [15:0] lo_len;

  cmd_t        in_cmd;
  logic        pm_valid;
  logic        res_ready;
  mapped_t     pm_item;
  logic        take;

  assign in_cmd.mode           = mode_t'(s_axis_tuser);
  assign in_cmd.target_id      = s_axis_tdata[7:0];
  assign in_cmd.direction      = s_axis_tdata[25:24];
  assign in_cmd.enable_request = s_axis_tdata[26];

  sdpg_period_map u_map (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_cmd     (in_cmd),
    .in_speed   ($signed(s_axis_tdata[23:8])),
    .period_max (period_max_us),
    .period_min (period_min_us),
    .out_valid  (pm_valid),
    .out_ready  (res_ready),
    .out_item   (pm_item)
  );

  assign res_ready = !m_axis_tvalid || m_axis_tready;
  assign take      = pm_valid && res_ready;

  always_comb begin
    run_flag_next        = run_flag;
    period_reg_next      = period_reg;
    dir_reg_next         = dir_reg;
    enabled_reg_next     = enabled_reg;
    high_phase_next      = high_phase;
    phase_left_next      = phase_left;
    low_len_latched_next = low_len_latched;
    step_next            = 1'b0;
    hi_len               = {1'b0, period_reg[15:1]};
    lo_len               = period_reg - hi_len;
    if (hi_len < MIN_PHASE) hi_len = MIN_PHASE;
    if (lo_len < MIN_PHASE) lo_len = MIN_PHASE;

    case (pm_item.cmd.mode)
      MODE_TICK: begin
        if (run_flag) begin
          if (phase_left == '0) begin
            high_phase_next      = 1'b1;
            phase_left_next      = hi_len;
            low_len_latched_next = lo_len;
          end
          step_next       = high_phase_next;
          phase_left_next = phase_left_next - 16'd1;
          if (phase_left_next == '0 && high_phase_next) begin
            high_phase_next = 1'b0;
            phase_left_next = low_len_latched_next;
          end
        end
      end
      MODE_SPEED: begin
        if (pm_item.cmd.target_id == unit_id) begin
          if (pm_item.cmd.direction == DIRN_NONE || pm_item.speed_zero) begin
            run_flag_next    = 1'b0;
            high_phase_next  = 1'b0;
            phase_left_next  = '0;
            enabled_reg_next = 1'b1;
          end else begin
            dir_reg_next     = (pm_item.cmd.direction == DIRN_FWD);
            period_reg_next  = pm_item.period;
            enabled_reg_next = 1'b1;
            run_flag_next    = 1'b1;
          end
        end
        step_next = run_flag_next && high_phase_next;
      end
      MODE_ENABLE: begin
        if (pm_item.cmd.target_id == unit_id || pm_item.cmd.target_id == BROADCAST_ID) begin
          enabled_reg_next = pm_item.cmd.enable_request;
        end
        step_next = run_flag && high_phase;
      end
      MODE_STOP: begin
        run_flag_next    = 1'b0;
        high_phase_next  = 1'b0;
        phase_left_next  = '0;
        enabled_reg_next = 1'b1;
      end
      default: begin
        step_next = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      period_max_us       <= PERIOD_MAX_RST;
      period_min_us       <= PERIOD_MIN_RST;
      enable_active_level <= 1'b1;
      unit_id             <= UNIT_ID_RST;
      run_flag            <= 1'b0;
      period_reg          <= RESET_PERIOD;
      dir_reg             <= 1'b1;
      enabled_reg         <= 1'b1;
      high_phase          <= 1'b0;
      phase_left          <= '0;
      low_len_latched     <= '0;
      m_axis_tvalid       <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_PERIOD_MAX: period_max_us       <= cfg_data;
          CFG_PERIOD_MIN: period_min_us       <= cfg_data;
          CFG_ENABLE_LVL: enable_active_level <= cfg_data[0];
          CFG_UNIT_ID:    unit_id             <= cfg_data[7:0];
          default: begin
          end
        endcase
      end
      if (res_ready) m_axis_tvalid <= pm_valid;
      if (take) begin
        run_flag        <= run_flag_next;
        period_reg      <= period_reg_next;
        dir_reg         <= dir_reg_next;
        enabled_reg     <= enabled_reg_next;
        high_phase      <= high_phase_next;
        phase_left      <= phase_left_next;
        low_len_latched <= low_len_latched_next;
      end
    end
    if (take) begin
      m_axis_tdata <= {4'd0, period_reg_next, run_flag_next,
                       enabled_reg_next ? enable_active_level : ~enable_active_level,
                       dir_reg_next, step_next};
    end
  end

  `SDPG_ASSERT_NOW(a_stop_clears_phase, !run_flag, !high_phase && phase_left == '0, "stale phase")
  `SDPG_ASSERT_NOW(a_high_has_count, run_flag && high_phase, phase_left != '0, "empty high")
  `SDPG_ASSERT_NOW(a_low_len_latched, high_phase, low_len_latched >= MIN_PHASE, "short low")
  `SDPG_ASSERT_NOW(a_step_needs_run, m_axis_tvalid && m_axis_tdata[0], m_axis_tdata[3], "idle step")
  `SDPG_ASSERT_NEXT(a_result_follows, take, m_axis_tvalid, "taken result not presented")

endmodule

`default_nettype wire

>>> bench/tb.sv
// Testbench for step_dir_pulse_generator: sends tick and command beats with
// random gaps and back-pressure, predicts every result beat and compares it.
// Depends on sdpg_pkg and the block's RTL; needs no other file.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import sdpg_pkg::*;

  localparam logic [1:0] DIR_REVERSE     = 2'd2;
  localparam logic [1:0] DIR_REVERSE_ALT = 2'd3;
  localparam int PHASES          = 6;
  localparam int ITEMS_PER_PHASE = 250;
  localparam int LONG_HOLD       = 120;
  localparam int STALL_LIMIT     = 2000;
  localparam int DRAIN_CYCLES    = 20;

  typedef struct {
    mode_t              mode;
    logic [7:0]         target_id;
    logic signed [15:0] speed_q8;
    logic [1:0]         direction;
    logic               enable_request;
  } command_t;

  typedef struct {
    logic        step;
    logic        dir;
    logic        enable_pin;
    logic        running;
    logic [15:0] period;
  } pins_t;

  class pin_tracker;
    logic [15:0] period_max;
    logic [15:0] period_min;
    logic        enable_level;
    logic [7:0]  unit_id_cfg;
    logic        running;
    logic        dir_fwd;
    logic        enabled;
    logic        step_high;
    logic [15:0] period;
    logic [15:0] phase_left;
    logic [15:0] low_len;
    pins_t       expected_pins[$];
    int          errors;

    function new();
      period_max   = PERIOD_MAX_RST;
      period_min   = PERIOD_MIN_RST;
      enable_level = 1'b1;
      unit_id_cfg  = UNIT_ID_RST;
      running      = 1'b0;
      dir_fwd      = 1'b1;
      enabled      = 1'b1;
      step_high    = 1'b0;
      period       = RESET_PERIOD;
      phase_left   = '0;
      low_len      = '0;
      errors       = 0;
    endfunction

    function void set_reg(logic [1:0] index, logic [15:0] value);
      case (index)
        CFG_PERIOD_MAX: period_max = value;
        CFG_PERIOD_MIN: period_min = value;
        CFG_ENABLE_LVL: enable_level = value[0];
        CFG_UNIT_ID:    unit_id_cfg = value[7:0];
      endcase
    endfunction

    function void halt();
      running    = 1'b0;
      step_high  = 1'b0;
      phase_left = '0;
      enabled    = 1'b1;
    endfunction

    function logic [15:0] speed_to_period(int s);
      longint full_speed = FULL_SPEED_Q8;
      longint mx = period_max;
      longint mn = period_min;
      longint num;
      longint q;
      num = mx * full_speed - (mx - mn) * s;
      if (num < 0) num = 0;
      q = num / full_speed;
      if (q < mn) q = mn;
      if (q > mx) q = mx;
      return q[15:0];
    endfunction

    function void apply_speed(command_t c);
      int full_speed = FULL_SPEED_Q8;
      int s;
      s = c.speed_q8;
      if (c.target_id != unit_id_cfg) return;
      if (s > full_speed) s = full_speed;
      if (s < 0) s = 0;
      if (c.direction == DIRN_NONE || s == 0) begin
        halt();
        return;
      end
      dir_fwd = (c.direction == DIRN_FWD);
      period  = speed_to_period(s);
      enabled = 1'b1;
      running = 1'b1;
    endfunction

    function void note_command(command_t c);
      pins_t       p;
      logic [15:0] hi;
      logic [15:0] lo;
      p.step = 1'b0;
      case (c.mode)
        MODE_TICK: begin
          if (running) begin
            // new pulse: latch both phase lengths from the current period
            if (phase_left == 0) begin
              hi = period >> 1;
              lo = period - hi;
              if (hi < MIN_PHASE) hi = MIN_PHASE;
              if (lo < MIN_PHASE) lo = MIN_PHASE;
              step_high  = 1'b1;
              phase_left = hi;
              low_len    = lo;
            end
            p.step = step_high;
            phase_left = phase_left - 1'b1;
            if (phase_left == 0 && step_high) begin
              step_high  = 1'b0;
              phase_left = low_len;
            end
          end
        end
        MODE_SPEED: apply_speed(c);
        MODE_ENABLE: begin
          if (c.target_id == unit_id_cfg || c.target_id == BROADCAST_ID)
            enabled = c.enable_request;
        end
        MODE_STOP: halt();
      endcase
      if (c.mode != MODE_TICK) p.step = running & step_high;
      p.dir        = dir_fwd;
      p.enable_pin = enabled ? enable_level : ~enable_level;
      p.running    = running;
      p.period     = period;
      expected_pins.push_back(p);
    endfunction

    function void compare(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      end
    endfunction

    function void check_pins(logic [23:0] data);
      pins_t want;
      if (expected_pins.size() == 0) begin
        errors++;
        $display("%0t: result beat %h with nothing expected", $time, data);
        return;
      end
      want = expected_pins.pop_front();
      compare("step_level", want.step, data[0]);
      compare("dir_level", want.dir, data[1]);
      compare("enable_pin_level", want.enable_pin, data[2]);
      compare("running", want.running, data[3]);
      compare("period_us", want.period, data[19:4]);
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;
  logic [1:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;

  pin_tracker tracker;
  bit         quiet = 1'b0;
  bit         long_hold = 1'b0;
  int         idle_cycles = 0;

  step_dir_pulse_generator DUT (
    .clk,
    .rst,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .s_axis_tuser,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .cfg_we,
    .cfg_index,
    .cfg_data
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // mostly back to back, some short gaps, the odd long one
  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic signed [15:0] pick_speed();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 16'($urandom_range(1, 25600));
    if (r < 65) return 16'($urandom_range(1, 300));
    if (r < 80) return 16'($urandom_range(0, 65535));
    case ($urandom_range(0, 5))
      0: return 16'sd0;
      1: return FULL_SPEED_Q8;
      2: return 16'sd25601;
      3: return 16'sh7FFF;
      4: return 16'sh8000;
      default: return -16'sd1;
    endcase
  endfunction

  function automatic command_t random_command();
    command_t c;
    int       r;
    int       sel;
    r   = $urandom_range(0, 99);
    sel = $urandom_range(0, 99);
    if (r < 80) c.mode = MODE_TICK;
    else if (r < 90) c.mode = MODE_SPEED;
    else if (r < 97) c.mode = MODE_ENABLE;
    else c.mode = MODE_STOP;
    c.target_id      = 8'($urandom_range(0, 255));
    c.speed_q8       = 16'($urandom_range(0, 65535));
    c.direction      = 2'($urandom_range(0, 3));
    c.enable_request = 1'($urandom_range(0, 1));
    if (c.mode == MODE_SPEED) begin
      if (sel < 85) c.target_id = tracker.unit_id_cfg;
      c.speed_q8 = pick_speed();
      if ($urandom_range(0, 9) != 0) c.direction = 2'($urandom_range(1, 3));
      else c.direction = DIRN_NONE;
    end else if (c.mode == MODE_ENABLE) begin
      if (sel < 40) c.target_id = tracker.unit_id_cfg;
      else if (sel < 70) c.target_id = BROADCAST_ID;
    end
    return c;
  endfunction

  task automatic send_command(command_t c, int gap);
    repeat (gap) begin
      @(negedge clk);
      s_axis_tvalid = 1'b0;
    end
    @(negedge clk);
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = c.mode;
    s_axis_tdata  = {5'b0, c.enable_request, c.direction, c.speed_q8, c.target_id};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    tracker.note_command(c);
  endtask

  task automatic issue(mode_t m, logic [7:0] id, logic signed [15:0] s, logic [1:0] d,
                       logic en);
    command_t c;
    c.mode           = m;
    c.target_id      = id;
    c.speed_q8       = s;
    c.direction      = d;
    c.enable_request = en;
    send_command(c, pick_gap());
  endtask

  task automatic ticks(int n);
    repeat (n) issue(MODE_TICK, 8'($urandom_range(0, 255)), 16'($urandom), 2'($urandom), 1'b0);
  endtask

  task automatic drain();
    @(negedge clk);
    s_axis_tvalid = 1'b0;
    while (tracker.expected_pins.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] index, logic [15:0] value);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = index;
    cfg_data  = value;
    tracker.set_reg(index, value);
  endtask

  task automatic write_settings(logic [15:0] pmax, logic [15:0] pmin, logic lvl,
                                logic [7:0] id);
    write_reg(CFG_PERIOD_MAX, pmax);
    write_reg(CFG_PERIOD_MIN, pmin);
    write_reg(CFG_ENABLE_LVL, {15'b0, lvl});
    write_reg(CFG_UNIT_ID, {8'b0, id});
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // result side: random stalls, plus one long hold-off on request
  initial begin
    int stall;
    stall = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold) begin
        stall = LONG_HOLD;
        long_hold = 1'b0;
      end
      if (stall > 0) begin
        m_axis_tready = 1'b0;
        stall--;
      end else begin
        m_axis_tready = 1'b1;
        stall = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) tracker.check_pins(m_axis_tdata);
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("step_dir_pulse_generator test failed");
      $finish;
    end
  end

  initial begin
    command_t    c;
    int          pause_at;
    int          hold_at;
    logic [15:0] pmax;
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = MODE_TICK;
    cfg_we        = 1'b0;
    cfg_index     = CFG_PERIOD_MAX;
    cfg_data      = '0;
    tracker       = new();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // reset defaults
    ticks(1);
    issue(MODE_SPEED, 8'd1, 16'sd12800, DIRN_FWD, 1'b0);
    ticks(2);
    issue(MODE_STOP, 8'd9, 16'sd0, DIRN_FWD, 1'b0);

    drain();
    write_settings(16'd10, 16'd4, 1'b1, 8'd1);
    ticks(1);
    issue(MODE_SPEED, 8'd1, FULL_SPEED_Q8, DIRN_FWD, 1'b0);
    ticks(5);
    // above full speed clamps; direction 3 means reverse
    issue(MODE_SPEED, 8'd1, 16'sd30000, DIR_REVERSE_ALT, 1'b0);
    issue(MODE_SPEED, 8'd1, -16'sd5, DIRN_FWD, 1'b0);
    issue(MODE_SPEED, 8'd1, 16'sd256, DIR_REVERSE, 1'b0);
    ticks(3);
    issue(MODE_SPEED, 8'd2, FULL_SPEED_Q8, DIRN_FWD, 1'b0);
    issue(MODE_SPEED, BROADCAST_ID, FULL_SPEED_Q8, DIRN_FWD, 1'b0);
    issue(MODE_ENABLE, 8'd1, 16'sd0, DIRN_NONE, 1'b0);
    ticks(2);
    issue(MODE_ENABLE, BROADCAST_ID, 16'sd0, DIRN_NONE, 1'b1);
    issue(MODE_ENABLE, 8'd7, 16'sd0, DIRN_NONE, 1'b0);
    issue(MODE_SPEED, 8'd1, 16'sd100, DIRN_NONE, 1'b0);
    issue(MODE_SPEED, 8'd1, 16'sh8000, DIRN_FWD, 1'b0);
    issue(MODE_SPEED, 8'd1, 16'sh7FFF, DIRN_FWD, 1'b1);
    issue(MODE_STOP, 8'd200, 16'sd0, DIRN_FWD, 1'b1);
    ticks(1);

    for (int ph = 0; ph < PHASES; ph++) begin
      drain();
      case (ph)
        0: write_settings(16'd12, 16'd4, 1'b0, 8'd0);
        1: write_settings(16'hFFFF, 16'd2, 1'b1, 8'd254);
        2: write_settings(16'd2, 16'd2, 1'b0, 8'd77);
        3: write_settings(16'd5, 16'd9, 1'b1, 8'd3);
        4: write_settings(16'd40, 16'd3, 1'b1, 8'd200);
        default: begin
          pmax = 16'($urandom_range(2, 300));
          write_settings(pmax, 16'($urandom_range(2, pmax)), 1'($urandom_range(0, 1)),
                         8'($urandom_range(0, 254)));
        end
      endcase
      quiet    = (ph == 2);
      pause_at = $urandom_range(50, 200);
      hold_at  = $urandom_range(20, 80);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (ph == 1 && n == pause_at) drain();
        if (ph == 3 && n == hold_at) long_hold = 1'b1;
        c = random_command();
        if (ph == 3 && n >= hold_at && n < hold_at + 150) send_command(c, 0);
        else send_command(c, pick_gap());
      end
    end

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tracker.errors == 0)
      $display("step_dir_pulse_generator test passed");
    else
      $display("step_dir_pulse_generator test failed");
    $finish;
  end

endmodule

>>> filelist.f
+incdir+rtl
rtl/sdpg_pkg.sv
rtl/sdpg_period_map.sv
rtl/step_dir_pulse_generator.sv
bench/tb.sv
